// File: src/skt_pkg.sv
// skt_pkg: shared constants and codes for the sorted key table
// no dependencies; imported by skt_mem and sorted_key_table
package skt_pkg;

    // default sizing of the table
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int MAXE_W   = 7;

    localparam logic [MAXE_W-1:0] MAXE_RESET = 7'd64;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2,
        STATUS_RSVD = 2'd3
    } status_t;

endpackage

// File: src/skt_mem.sv
// skt_mem: key and value storage for the sorted key table
// one write port, one read port with registered read data; uses skt_pkg
module skt_mem
    import skt_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int KEY_W = KEY_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [KEY_W-1:0]         wr_key,
    input  logic [VALUE_W-1:0]       wr_val,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [KEY_W-1:0]         rd_key,
    output logic [VALUE_W-1:0]       rd_val
);

    logic [KEY_W-1:0]   key_mem [DEPTH];
    logic [VALUE_W-1:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

endmodule

// File: src/sorted_key_table.sv
// sorted_key_table: sorted key/value table, top level with sequencer
// depends on skt_pkg and skt_mem
//
// Keeps up to CAPACITY key/value pairs sorted by unsigned key, like a B+ tree
// leaf. Each input word is an insert, a lookup or a remove and produces one
// result word carrying a status, a value (lookups only, else zero) and the
// entry count after the operation. Only the low KEY_WIDTH bits of the key are
// used. An insert lands before any equal keys and is refused with full status
// once the count reaches max_entries (saturated to CAPACITY; zero refuses all
// inserts). Lookup and remove act on the first equal key. The block works on
// one word at a time; in_stall stays high from acceptance until the result is
// handed to the output register, which can still hold the previous result
// while the next word is accepted. All work goes through a single memory read
// port and one key comparator, with a read state and a compare or write state
// per visited entry. A lookup scans up to the lower-bound position, an insert
// also shifts every entry from there up to the count, a remove of a held key
// shifts the entries above it, a remove of a missing key works as a lookup,
// and a refused insert or an unused kind skips the scan; any stall of the
// output register delays the next acceptance.
// The memories need no clearing after reset, since only entries below the
// count are ever read.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [MAXE_W-1:0]               cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [KIND_W-1:0]               kind,
    input  logic [KEY_IN_W-1:0]             key,
    input  logic [VALUE_W-1:0]              value_in,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [STATUS_W-1:0]             status,
    output logic [VALUE_W-1:0]              value_out,
    output logic [$clog2(CAPACITY+1)-1:0]   entry_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int LW    = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam int XW    = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SRCH_RD  = 8'b0000_0010,
        ST_SRCH_CMP = 8'b0000_0100,
        ST_DECIDE   = 8'b0000_1000,
        ST_UP_RD    = 8'b0001_0000,
        ST_UP_WR    = 8'b0010_0000,
        ST_DN_RD    = 8'b0100_0000,
        ST_DN_WR    = 8'b1000_0000
    } state_t;

    // ST_DONE folds into the idle-bound handoff below
    localparam state_t ST_DONE = ST_IDLE;

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;        // result waits for output slot
    logic [MAXE_W-1:0]    max_entries_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;          // lower-bound scan position
    logic [CNT_W-1:0]     idx_reg, idx_next;          // shift cursor
    kind_t                kind_reg, kind_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic                 hit_reg, hit_next;
    logic [VALUE_W-1:0]   hitval_reg, hitval_next;
    status_t              res_status_reg, res_status_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [VALUE_W-1:0]   value_out_reg, value_out_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;

    // memory port
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_key;
    logic [VALUE_W-1:0]   wr_val;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [VALUE_W-1:0]   rd_val;

    logic [XW-1:0]        key_x;
    logic                 full;
    logic                 accept;
    logic                 handoff;

    skt_mem #(
        .DEPTH (CAPACITY),
        .KEY_W (KEY_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_val  (wr_val),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val)
    );

    // key trimmed or widened to the stored key width
    assign key_x = XW'(key);

    // table at its limit; count never exceeds CAPACITY
    assign full = (LW'(count_reg) >= LW'(max_entries_reg))
               || (count_reg == CNT_W'(CAPACITY));

    // idle and no finished result still parked in the sequencer
    assign in_stall = !((state_reg == ST_IDLE) && !done_reg);
    assign accept   = in_valid && !in_stall;

    // finished result moves into the output register when it is free
    assign handoff  = done_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_next        = hit_reg;
        hitval_next     = hitval_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_key          = rd_key;
        wr_val          = rd_val;
        rd_addr         = pos_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = kind_t'(kind);
                    key_next       = key_x[KEY_WIDTH-1:0];
                    val_next       = value_in;
                    pos_next       = '0;
                    res_value_next = '0;
                    if (kind_t'(kind) == KIND_INSERT && full)
                    begin
                        res_status_next = STATUS_FULL;
                        done_next       = 1'b1;
                    end
                    else if (kind_t'(kind) == KIND_NONE)
                    begin
                        res_status_next = STATUS_MISS;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end

            // scan reaches the end of the table or issues a read
            ST_SRCH_RD:
            begin
                rd_addr = pos_reg[AW-1:0];
                if (pos_reg == count_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end

            // the shared comparator: stored key against search key
            ST_SRCH_CMP:
            begin
                if (rd_key < key_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    hit_next    = (rd_key == key_reg);
                    hitval_next = rd_val;
                    state_next  = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        idx_next   = count_reg;
                        state_next = ST_UP_RD;
                    end
                    KIND_LOOKUP:
                    begin
                        res_status_next = hit_reg ? STATUS_OK : STATUS_MISS;
                        res_value_next  = hit_reg ? hitval_reg : '0;
                        done_next       = 1'b1;
                        state_next      = ST_DONE;
                    end
                    KIND_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            idx_next   = pos_reg;
                            state_next = ST_DN_RD;
                        end
                        else
                        begin
                            res_status_next = STATUS_MISS;
                            done_next       = 1'b1;
                            state_next      = ST_DONE;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_MISS;
                        done_next       = 1'b1;
                        state_next      = ST_DONE;
                    end
                endcase
            end

            // open a gap at pos by moving entries up, top first
            ST_UP_RD:
            begin
                rd_addr = idx_reg[AW-1:0] - 1'b1;
                if (idx_reg == pos_reg)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = pos_reg[AW-1:0];
                    wr_key          = key_reg;
                    wr_val          = val_reg;
                    count_next      = count_reg + 1'b1;
                    res_status_next = STATUS_OK;
                    done_next       = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_UP_WR;
                end
            end

            ST_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg - 1'b1;
                state_next = ST_UP_RD;
            end

            // close the hole at pos by moving later entries down
            ST_DN_RD:
            begin
                rd_addr = idx_reg[AW-1:0] + 1'b1;
                if ((idx_reg + 1'b1) >= count_reg)
                begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = STATUS_OK;
                    done_next       = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN_WR;
                end
            end

            ST_DN_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = ST_DN_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (handoff)
        begin
            done_next = 1'b0;
        end
    end

    // output register: loaded on handoff, cleared once taken
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        value_out_next   = value_out_reg;
        entry_count_next = entry_count_reg;
        if (handoff)
        begin
            out_valid_next   = 1'b1;
            status_next      = res_status_reg;
            value_out_next   = res_value_reg;
            entry_count_next = count_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            count_reg       <= '0;
            max_entries_reg <= MAXE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        hit_reg         <= hit_next;
        hitval_reg      <= hitval_next;
        res_status_reg  <= res_status_next;
        res_value_reg   <= res_value_next;
        status_reg      <= status_next;
        value_out_reg   <= value_out_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // count moves by at most one per word
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    // a new result appears only from a finished word
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_reg))
        else $error("result without finished word");

    // memory is written only while a word is being worked on
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE) && !done_reg)
        else $error("table write while idle");
`endif

endmodule
